// ===== design/slcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcp_pkg
// Types and constants shared by the sound log command parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slcp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_CMD    = 2'd0,
        PH_REG    = 2'd1,
        PH_VAL    = 2'd2,
        PH_VARINT = 2'd3
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_EVAL   = 3'd1,
        ST_MUL    = 3'd2,
        ST_DIV    = 3'd3,
        ST_COMMIT = 3'd4
    } state_t;

    // Result kinds
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_KEY = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_CMD01    = 3'd0;
    localparam logic [2:0] ERR_BAD_CMD  = 3'd1;
    localparam logic [2:0] ERR_VARINT   = 3'd2;
    localparam logic [2:0] ERR_BAD_REG  = 3'd3;
    localparam logic [2:0] ERR_BAD_KEY  = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;
    localparam logic [2:0] ERR_TRUNC    = 3'd6;

    // Command bytes
    localparam logic [7:0] CMD_WRITE = 8'h00;
    localparam logic [7:0] CMD_OPN   = 8'h01;
    localparam logic [7:0] CMD_SYNC  = 8'hff;
    localparam logic [7:0] CMD_WAIT  = 8'hfe;
    localparam logic [7:0] CMD_END   = 8'hfd;

    localparam logic [7:0]  KEY_REG      = 8'h28;
    localparam logic [15:0] FRAME_RATE   = 16'd48000;
    localparam logic [31:0] DEF_NUM      = 32'd10;
    localparam logic [31:0] DEF_DEN      = 32'd1000;
    localparam logic [6:0]  MUL_LAST     = 7'd63;
    localparam logic [6:0]  DIV_LAST     = 7'd111;

    // Register index on the configuration port
    localparam logic CFG_NUM = 1'b0;
    localparam logic CFG_DEN = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic mul_step;
        logic div_step;
        logic commit;
    } slcp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_frame;
        logic out_free;
    } slcp_stat_t;

    // Register whitelist for plain register writes
    function automatic logic reg_allowed(input logic [7:0] r);
        logic ok;
        ok = 1'b0;
        if (r >= 8'h30 && r <= 8'h9f) begin
            ok = (r[1:0] != 2'b11);
        end else begin
            ok = (r >= 8'ha0 && r <= 8'ha2) || (r >= 8'ha4 && r <= 8'ha6) ||
                 (r >= 8'hb0 && r <= 8'hb2);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/slcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcp_ctrl
// Sequencer: accepts a byte, runs the timestamp multiply and divide when the
// byte needs a frame, then commits the parser update.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_ctrl
    import slcp_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  slcp_stat_t stat,
    output slcp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.need_frame) begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/slcp_dp.sv =====
// ----------------------------------------------------------------------------
// slcp_dp
// Datapath: parser state, timer registers, bit-serial multiply and restoring
// divide for the frame stamp, and the output item register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_dp
    import slcp_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  slcp_cmd_t    cmd,
    output slcp_stat_t   stat,
    input  wire  [7:0]   in_byte,
    input  wire          in_last,
    input  wire          cfg_we,
    input  wire          cfg_idx,
    input  wire  [31:0]  cfg_wdata,
    output logic [31:0]  cfg_rdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [223:0] m_tdata,
    output logic [1:0]   m_tuser
);

    localparam logic [63:0] U64MAX = '1;

    // Timer registers
    logic [31:0] num_reg, den_reg;
    logic [31:0] num_eff, den_eff;

    // Parser state
    logic [7:0]  byte_reg;
    logic        last_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [63:0] sync_reg, sync_next;
    logic [63:0] vacc_reg, vacc_next;
    logic [6:0]  vshift_reg, vshift_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] lastf_reg, lastf_next;
    logic        seen_reg, seen_next;
    logic        halted_reg, halted_next;

    // Multiply and divide
    logic [47:0]  b_reg;
    logic [63:0]  a_reg;
    logic [111:0] acc_reg;
    logic [31:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic [32:0]  rem_sh;
    logic [32:0]  rem_sub;
    logic         div_ge;

    // Output item
    logic         out_valid_reg;
    logic [1:0]   kind_reg;
    logic [220:0] pay_reg;

    // Commit results
    logic         o_valid;
    logic [1:0]   o_kind;
    logic [7:0]   o_addr, o_value, o_slots;
    logic [1:0]   o_chan;
    logic [63:0]  o_frame, o_index;
    logic [2:0]   o_err;
    logic         fail, trunc_ok;
    logic [2:0]   fail_code;
    logic [63:0]  vnew;
    logic [64:0]  vsum;

    assign num_eff = (num_reg == '0) ? DEF_NUM : num_reg;
    assign den_eff = (den_reg == '0) ? DEF_DEN : den_reg;

    assign cfg_rdata = (cfg_idx == CFG_DEN) ? den_reg : num_reg;

    assign stat.need_frame = !halted_reg &&
        (phase_reg == PH_VAL || (phase_reg == PH_CMD && byte_reg == CMD_END));
    assign stat.out_free = !out_valid_reg || m_tready;

    // Restoring divide step
    assign rem_sh  = {rem_reg, acc_reg[111]};
    assign div_ge  = rem_sh >= {1'b0, den_eff};
    assign rem_sub = rem_sh - {1'b0, den_eff};

    // Parser update for the held byte
    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        sync_next   = sync_reg;
        vacc_next   = vacc_reg;
        vshift_next = vshift_reg;
        seq_next    = seq_reg;
        lastf_next  = lastf_reg;
        seen_next   = seen_reg;
        halted_next = halted_reg;
        o_valid     = 1'b0;
        o_kind      = KIND_REG;
        o_addr      = '0;
        o_value     = '0;
        o_chan      = '0;
        o_slots     = '0;
        o_frame     = '0;
        o_index     = '0;
        o_err       = '0;
        fail        = 1'b0;
        fail_code   = ERR_CMD01;
        trunc_ok    = 1'b1;
        vnew        = vacc_reg | (64'(byte_reg[6:0]) << vshift_reg[5:0]);
        vsum        = {1'b0, sync_reg} + {1'b0, vnew} + 65'd2;
        if (!halted_reg) begin
            case (phase_reg)
                PH_REG: begin
                    held_next  = byte_reg;
                    phase_next = PH_VAL;
                end
                PH_VAL: begin
                    phase_next = PH_CMD;
                    if (seq_reg == U64MAX || ovf_reg) begin
                        fail = 1'b1; fail_code = ERR_OVERFLOW;
                    end else if (held_reg == KEY_REG) begin
                        if (byte_reg[2] || byte_reg[1:0] == 2'b11) begin
                            fail = 1'b1; fail_code = ERR_BAD_KEY;
                        end else begin
                            o_valid = 1'b1;
                            o_kind  = KIND_KEY;
                            o_chan  = byte_reg[1:0];
                            o_slots = {byte_reg[7:4], 4'b0};
                        end
                    end else if (!reg_allowed(held_reg)) begin
                        fail = 1'b1; fail_code = ERR_BAD_REG;
                    end else begin
                        o_valid = 1'b1;
                        o_kind  = KIND_REG;
                        o_addr  = held_reg;
                        o_value = byte_reg;
                    end
                    if (o_valid) begin
                        o_frame    = q_reg;
                        o_index    = seq_reg;
                        seq_next   = seq_reg + 64'd1;
                        lastf_next = q_reg;
                        seen_next  = 1'b1;
                    end
                end
                PH_VARINT: begin
                    if (vshift_reg > 7'd63 ||
                        (vshift_reg == 7'd63 && byte_reg[6:0] > 7'd1)) begin
                        fail = 1'b1; fail_code = ERR_VARINT;
                    end else begin
                        vacc_next = vnew;
                        if (!byte_reg[7]) begin
                            phase_next = PH_CMD;
                            if (vnew > U64MAX - 64'd2) begin
                                fail = 1'b1; fail_code = ERR_VARINT;
                            end else if (vsum[64]) begin
                                fail = 1'b1; fail_code = ERR_OVERFLOW;
                            end else begin
                                sync_next = vsum[63:0];
                            end
                        end else begin
                            vshift_next = vshift_reg + 7'd7;
                        end
                    end
                end
                default: begin
                    case (byte_reg)
                        CMD_WRITE: phase_next = PH_REG;
                        CMD_OPN: begin
                            fail = 1'b1; fail_code = ERR_CMD01;
                        end
                        CMD_SYNC: begin
                            if (sync_reg == U64MAX) begin
                                fail = 1'b1; fail_code = ERR_OVERFLOW;
                            end else begin
                                sync_next = sync_reg + 64'd1;
                            end
                        end
                        CMD_WAIT: begin
                            vacc_next   = '0;
                            vshift_next = '0;
                            phase_next  = PH_VARINT;
                        end
                        CMD_END: begin
                            trunc_ok = 1'b0;
                            if (ovf_reg || (seen_reg && q_reg < lastf_reg)) begin
                                fail = 1'b1; fail_code = ERR_OVERFLOW;
                            end else begin
                                o_valid     = 1'b1;
                                o_kind      = KIND_END;
                                o_frame     = q_reg;
                                o_index     = seq_reg;
                                halted_next = 1'b1;
                            end
                        end
                        default: begin
                            fail = 1'b1; fail_code = ERR_BAD_CMD;
                        end
                    endcase
                end
            endcase
            // Replace any event other than an end by a truncation error on the last byte
            if (!fail && trunc_ok && last_reg) begin
                fail = 1'b1; fail_code = ERR_TRUNC;
            end
            if (fail) begin
                o_valid     = 1'b1;
                o_kind      = KIND_ERR;
                o_addr      = '0;
                o_value     = '0;
                o_chan      = '0;
                o_slots     = '0;
                o_frame     = '0;
                o_index     = seq_next;
                o_err       = fail_code;
                halted_next = 1'b1;
            end
        end
    end

    // Control state: timers, parser, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg       <= DEF_NUM;
            den_reg       <= DEF_DEN;
            phase_reg     <= PH_CMD;
            held_reg      <= '0;
            sync_reg      <= '0;
            vacc_reg      <= '0;
            vshift_reg    <= '0;
            seq_reg       <= '0;
            lastf_reg     <= '0;
            seen_reg      <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                // Restart the stream on any register write
                if (cfg_idx == CFG_NUM) begin
                    num_reg <= cfg_wdata;
                end else begin
                    den_reg <= cfg_wdata;
                end
                phase_reg  <= PH_CMD;
                held_reg   <= '0;
                sync_reg   <= '0;
                vacc_reg   <= '0;
                vshift_reg <= '0;
                seq_reg    <= '0;
                lastf_reg  <= '0;
                seen_reg   <= 1'b0;
                halted_reg <= 1'b0;
            end else if (cmd.commit) begin
                phase_reg  <= phase_next;
                held_reg   <= held_next;
                sync_reg   <= sync_next;
                vacc_reg   <= vacc_next;
                vshift_reg <= vshift_next;
                seq_reg    <= seq_next;
                lastf_reg  <= lastf_next;
                seen_reg   <= seen_next;
                halted_reg <= halted_next;
                if (o_valid) begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: input byte, arithmetic, output item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.start) begin
            b_reg   <= 48'(num_eff) * 48'(FRAME_RATE);
            a_reg   <= sync_reg;
            acc_reg <= '0;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.mul_step) begin
            acc_reg <= {acc_reg[110:0], 1'b0} + (a_reg[63] ? {64'b0, b_reg} : 112'b0);
            a_reg   <= {a_reg[62:0], 1'b0};
        end else if (cmd.div_step) begin
            acc_reg <= {acc_reg[110:0], 1'b0};
            rem_reg <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], div_ge};
            ovf_reg <= ovf_reg | q_reg[63];
        end
        if (cmd.commit && o_valid) begin
            kind_reg <= o_kind;
            pay_reg  <= {o_err, sync_next, o_index, o_frame, o_slots, o_chan,
                         o_value, o_addr};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b0, pay_reg};

endmodule

`default_nettype wire

// ===== design/sound_log_command_parser.sv =====
// Timing: a byte that needs no frame stamp passes from acceptance through the
//   evaluate and commit states; the value byte of a register or key write and
//   FD first run a 64-step bit-serial multiply and a 112-step restoring divide.
// Throughput: one byte at a time; the next byte is taken once the current
//   one has committed and the output register is free.
// Reset: synchronous, active low; timers return to 10/1000, stream restarts.
// ----------------------------------------------------------------------------
// sound_log_command_parser
// Parses an FM sound log command stream into register, key, end and error
// items; register, key and end items are stamped with a 48 kHz frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_log_command_parser
    import slcp_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    // Command byte input
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire          s_tlast,   // data_end
    // Result output
    output logic         m_tvalid,
    input  wire          m_tready,
    // [7:0] register_addr, [15:8] register_value, [17:16] key_channel,
    // [25:18] key_slots, [89:26] frame_time, [153:90] event_index,
    // [217:154] total_syncs, [220:218] error_code
    output logic [223:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    // Configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    slcp_cmd_t  cmd;
    slcp_stat_t stat;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    slcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slcp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_idx   (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sound log command parser. Byte streams are
// pushed through the input channel while a behavioral predictor builds the
// expected items; a checker compares every result item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import slcp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] U64_MAX   = 64'hffff_ffff_ffff_ffff;
    localparam int          WDOG_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [7:0]  value;
        logic [1:0]  channel;
        logic [7:0]  slots;
        logic [63:0] frame;
        logic [63:0] index;
        logic [63:0] syncs;
        logic [2:0]  code;
    } log_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    sound_log_command_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    // Predictor state
    log_item_t   pending_items[$];
    logic [31:0] timer_num, timer_den;
    phase_t      phase;
    logic [7:0]  held_reg;
    logic [63:0] sync_tally, wait_accum, seq_next, last_frame;
    int          wait_shift;
    bit          seen_event, stopped;

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;

    function automatic bit stall_now();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    function automatic void clear_stream();
        phase = PH_CMD;
        held_reg = '0;
        sync_tally = '0;
        wait_accum = '0;
        wait_shift = 0;
        seq_next = '0;
        last_frame = '0;
        seen_event = 1'b0;
        stopped = 1'b0;
    endfunction

    // Frame for a sync count; returns 0 when it does not fit in 64 bits
    function automatic bit frame_at(input logic [63:0] syncs, output logic [63:0] frame);
        logic [127:0] prod, n, d;
        n = (timer_num == 0) ? 128'(DEF_NUM) : 128'(timer_num);
        d = (timer_den == 0) ? 128'(DEF_DEN) : 128'(timer_den);
        prod = (128'(syncs) * (n * 128'd48000)) / d;
        frame = prod[63:0];
        return prod[127:64] == 0;
    endfunction

    function automatic bit on_whitelist(input logic [7:0] r);
        if (r >= 8'h30 && r <= 8'h9f) return r[1:0] != 2'b11;
        return (r inside {[8'ha0:8'ha2], [8'ha4:8'ha6], [8'hb0:8'hb2]});
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        log_item_t e;
        e = '0;
        e.kind = KIND_ERR;
        e.index = seq_next;
        e.syncs = sync_tally;
        e.code = code;
        pending_items.push_back(e);
        stopped = 1'b1;
    endfunction

    // Advance the parser model by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input bit last);
        log_item_t   e;
        logic [63:0] fr, payload;
        bit          emit;
        e = '0;
        emit = 1'b0;
        if (stopped) return;
        case (phase)
            PH_REG: begin
                held_reg = b;
                phase = PH_VAL;
            end
            PH_VAL: begin
                phase = PH_CMD;
                if (seq_next == U64_MAX || !frame_at(sync_tally, fr)) begin
                    raise_error(ERR_OVERFLOW);
                    return;
                end
                if (held_reg == KEY_REG) begin
                    if (b[2] || b[1:0] == 2'b11) begin
                        raise_error(ERR_BAD_KEY);
                        return;
                    end
                    e.kind = KIND_KEY;
                    e.channel = b[1:0];
                    e.slots = b & 8'hf0;
                end else begin
                    if (!on_whitelist(held_reg)) begin
                        raise_error(ERR_BAD_REG);
                        return;
                    end
                    e.kind = KIND_REG;
                    e.addr = held_reg;
                    e.value = b;
                end
                e.frame = fr;
                e.index = seq_next;
                e.syncs = sync_tally;
                seq_next++;
                last_frame = fr;
                seen_event = 1'b1;
                emit = 1'b1;
            end
            PH_VARINT: begin
                payload = {57'd0, b[6:0]};
                if (wait_shift > 63 || (wait_shift == 63 && payload > 1)) begin
                    raise_error(ERR_VARINT);
                    return;
                end
                wait_accum |= payload << wait_shift;
                if (!b[7]) begin
                    phase = PH_CMD;
                    if (wait_accum > U64_MAX - 2) begin
                        raise_error(ERR_VARINT);
                        return;
                    end
                    if (wait_accum + 2 > U64_MAX - sync_tally) begin
                        raise_error(ERR_OVERFLOW);
                        return;
                    end
                    sync_tally += wait_accum + 2;
                end else begin
                    wait_shift += 7;
                end
            end
            default: begin
                case (b)
                    CMD_WRITE: phase = PH_REG;
                    CMD_OPN: begin
                        raise_error(ERR_CMD01);
                        return;
                    end
                    CMD_SYNC: begin
                        if (sync_tally == U64_MAX) begin
                            raise_error(ERR_OVERFLOW);
                            return;
                        end
                        sync_tally++;
                    end
                    CMD_WAIT: begin
                        wait_accum = '0;
                        wait_shift = 0;
                        phase = PH_VARINT;
                    end
                    CMD_END: begin
                        if (!frame_at(sync_tally, fr) || (seen_event && fr < last_frame)) begin
                            raise_error(ERR_OVERFLOW);
                            return;
                        end
                        e.kind = KIND_END;
                        e.frame = fr;
                        e.index = seq_next;
                        e.syncs = sync_tally;
                        pending_items.push_back(e);
                        stopped = 1'b1;
                        return;
                    end
                    default: begin
                        raise_error(ERR_BAD_CMD);
                        return;
                    end
                endcase
            end
        endcase
        // A last byte that did not finish the stream truncates it
        if (last) begin
            raise_error(ERR_TRUNC);
            return;
        end
        if (emit) pending_items.push_back(e);
    endfunction

    // Send one byte, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input bit last = 1'b0);
        if (stall_now()) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (stall_now());
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        parse_byte(b, last);
    endtask

    // FE command with its value as 7-bit groups, low group first
    task automatic send_wait(input logic [63:0] v, input bit last = 1'b0);
        send_byte(CMD_WAIT);
        while (v > 127) begin
            send_byte({1'b1, v[6:0]});
            v = v >> 7;
        end
        send_byte({1'b0, v[6:0]}, last);
    endtask

    task automatic send_write(input logic [7:0] r, input logic [7:0] v, input bit last = 1'b0);
        send_byte(CMD_WRITE);
        send_byte(r);
        send_byte(v, last);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drain all results and the block's pipeline, then load timers (restarts)
    task automatic set_timers(input logic [31:0] num, input logic [31:0] den);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        apb_write(3'd0, num);
        timer_num = num;
        clear_stream();
        @(posedge aclk);
        apb_write(3'd4, den);
        timer_den = den;
        clear_stream();
    endtask

    function automatic logic [31:0] pick_timer(input logic [31:0] typical);
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return $urandom();
            default: return typical;
        endcase
    endfunction

    task automatic test_commands();
        set_timers(32'd10, 32'd1000);
        send_write(8'h30, 8'h00);
        send_byte(CMD_SYNC);
        send_write(KEY_REG, 8'hf2);
        send_wait(64'd300);
        send_write(8'hb2, 8'hff);
        send_byte(CMD_END);
        send_byte(8'h55);               // dropped after the end
        set_timers(32'd0, 32'd0);
        send_write(KEY_REG, 8'h04);     // key with bit 2 set
        set_timers(32'hffff_ffff, 32'd1);
        send_write(KEY_REG, 8'h03);     // key on channel 3
        set_timers(32'd1, 32'hffff_ffff);
        send_write(8'ha3, 8'h12);       // register off the whitelist
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_OPN);
        set_timers(32'd10, 32'd1000);
        send_byte(8'h7e);               // unknown command
    endtask

    task automatic test_overflow();
        // Largest wait fills the sync count, one more sync overflows
        set_timers(32'd10, 32'd1000);
        send_wait(U64_MAX - 2);
        send_byte(CMD_SYNC);
        // Frame too large for 64 bits
        set_timers(32'd10, 32'd1000);
        send_wait(U64_MAX - 2);
        send_write(8'h40, 8'h01);
        // Wait value above the limit
        set_timers(32'd10, 32'd1000);
        send_wait(U64_MAX);
        // Oversized group at bit 63
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_WAIT);
        repeat (9) send_byte(8'h80);
        send_byte(8'h02);
        // Group past bit 63
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_WAIT);
        repeat (9) send_byte(8'hff);
        send_byte(8'h81);
        send_byte(8'h00);
        // Wait that wraps the sync count
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_SYNC);
        send_wait(U64_MAX - 2);
        // End frame that does not fit
        set_timers(32'hffff_ffff, 32'd1);
        send_wait(64'h0000_ffff_ffff_ffff);
        send_byte(CMD_END);
    endtask

    task automatic test_truncation();
        set_timers(32'd10, 32'd1000);
        send_write(8'h31, 8'h77, 1'b1);     // event replaced by truncation
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_WRITE, 1'b1);
        set_timers(32'd10, 32'd1000);
        send_wait(64'd5, 1'b1);
        set_timers(32'd10, 32'd1000);
        send_byte(CMD_END, 1'b1);           // proper end despite the mark
    endtask

    task automatic random_stream(input int len);
        int          n, sel;
        logic [7:0]  r;
        n = 0;
        while (n < len && !stopped) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                if ($urandom_range(3) == 0) begin
                    r = KEY_REG;
                end else begin
                    do r = 8'($urandom_range(8'h30, 8'hb2)); while (!on_whitelist(r));
                end
                if ($urandom_range(19) == 0) r = 8'($urandom_range(255));
                send_write(r, 8'($urandom_range(255)), $urandom_range(49) == 0);
                n += 3;
            end else if (sel < 65) begin
                send_byte(CMD_SYNC, $urandom_range(49) == 0);
                n++;
            end else if (sel < 85) begin
                if ($urandom_range(9) == 0) send_wait({$urandom(), $urandom()} >> $urandom_range(63));
                else send_wait(64'($urandom_range(400)));
                n += 3;
            end else begin
                send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
                n++;
            end
        end
        if (!stopped) begin
            if ($urandom_range(9) < 8) send_byte(CMD_END);
            else send_byte(CMD_SYNC, 1'b1);
        end
        if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic test_random();
        int target;
        target = bytes_sent + 1400;
        while (bytes_sent < target) begin
            calm = (bytes_sent > target - 1000) && (bytes_sent < target - 700);
            set_timers(pick_timer(32'd10), pick_timer(32'd1000));
            random_stream($urandom_range(4, 40));
        end
        calm = 1'b0;
    endtask

    // Check each result item against the oldest prediction
    always @(posedge aclk) begin
        log_item_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.addr    = m_tdata[7:0];
                got.value   = m_tdata[15:8];
                got.channel = m_tdata[17:16];
                got.slots   = m_tdata[25:18];
                got.frame   = m_tdata[89:26];
                got.index   = m_tdata[153:90];
                got.syncs   = m_tdata[217:154];
                got.code    = m_tdata[220:218];
                if (pending_items.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: kind %0d code %0d", got.kind, got.code);
                end else begin
                    want = pending_items.pop_front();
                    if (got.kind !== want.kind || got.addr !== want.addr ||
                        got.value !== want.value || got.channel !== want.channel ||
                        got.slots !== want.slots || got.frame !== want.frame ||
                        got.index !== want.index || got.syncs !== want.syncs ||
                        got.code !== want.code) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: kind %0d addr %h val %h ch %0d slots %h",
                                     want.kind, want.addr, want.value, want.channel, want.slots);
                            $display("   frame %0d idx %0d syncs %0d code %0d",
                                     want.frame, want.index, want.syncs, want.code);
                            $display("  got: kind %0d addr %h val %h ch %0d slots %h",
                                     got.kind, got.addr, got.value, got.channel, got.slots);
                            $display("   frame %0d idx %0d syncs %0d code %0d",
                                     got.frame, got.index, got.syncs, got.code);
                        end
                    end
                end
            end
            m_tready <= !stall_now();
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("** sound_log_command_parser: FAILED **");
            $finish;
        end
    end

    initial begin
        timer_num = DEF_NUM;
        timer_den = DEF_DEN;
        clear_stream();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_commands();
        test_overflow();
        test_truncation();
        test_random();
        s_tvalid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_items.size() == 0) begin
            $display("** sound_log_command_parser: PASSED **");
        end else begin
            $display("** sound_log_command_parser: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
